// File: rtl/romb_pkg.sv
package romb_pkg;

   // Dividend and quotient width of the Richardson division: a difference of two row values
   localparam int DIV_W = 49;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             rem_nz;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/romb_div.sv
module romb_div #(
   parameter int Q_W = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  romb_pkg::div_req_type   div_req,
   input  logic [Q_W-1:0]          divisor,
   output romb_pkg::div_rsp_type   div_rsp
);
   import romb_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [Q_W-1:0]   rem_ff, rem_in;

   logic [Q_W:0]     trial;
   logic [Q_W:0]     diff;
   logic             fits;

   // One quotient bit a cycle, restoring; the dividend shifts out as the quotient shifts in
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[Q_W-1:0] : trial[Q_W-1:0];
         num_in = {num_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign div_rsp = '{done: done_ff, rem_nz: |rem_ff, quotient: num_ff};

endmodule

// File: rtl/romberg_integrator_core.sv
// Romberg integrator: f(a) and each midpoint sample but a level's last take no stall.
// f(b) and the last sample of a level hold the input while the sum is scaled and the row
// is extrapolated: the scaling uses one shared 32x31 multiplier twice, and each
// Richardson term goes through a divider that makes one quotient bit a cycle (49 steps).
// The estimate sits in an output register, so the next run may start while it waits.
// Sync reset clears control state, sets default configuration; row memory is not cleared.
module romberg_integrator_core #(
   parameter int MAX_LEVELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_estimate,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);
   import romb_pkg::*;

   localparam int ROW_W = 48;
   localparam int T_W   = 52;
   localparam int S_W   = 50;
   localparam int LVL_W = $clog2(MAX_LEVELS + 1);
   localparam int IDX_W = $clog2(MAX_LEVELS);
   localparam int CNT_W = MAX_LEVELS - 1;
   localparam int Q_W   = 2 * (MAX_LEVELS - 1);

   localparam logic [3:0] CSR_LEVEL_COUNT    = 4'd0;
   localparam logic [3:0] CSR_INTERVAL_WIDTH = 4'd1;

   localparam logic [1:0] PH_FA  = 2'd0;
   localparam logic [1:0] PH_FB  = 2'd1;
   localparam logic [1:0] PH_MID = 2'd2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MAG    = 4'd1;
   localparam logic [3:0] S_MULH   = 4'd2;
   localparam logic [3:0] S_MULL   = 4'd3;
   localparam logic [3:0] S_SCALE  = 4'd4;
   localparam logic [3:0] S_TERM   = 4'd5;
   localparam logic [3:0] S_HALF   = 4'd6;
   localparam logic [3:0] S_RD     = 4'd7;
   localparam logic [3:0] S_DIFF   = 4'd8;
   localparam logic [3:0] S_DSTART = 4'd9;
   localparam logic [3:0] S_DWAIT  = 4'd10;
   localparam logic [3:0] S_RSUM   = 4'd11;
   localparam logic [3:0] S_RSAT   = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   localparam logic [63:0] TERM_CAP = 64'd1 << 50;

   // {clip, value}: clamp a wide value to the 48-bit row range
   function automatic logic [ROW_W:0] sat_row(input logic [T_W-1:0] v);
      logic [T_W-ROW_W:0] hi_bits;
      hi_bits = v[T_W-1:ROW_W-1];
      if (&hi_bits || ~|hi_bits) begin
         sat_row = {1'b0, v[ROW_W-1:0]};
      end else if (v[T_W-1]) begin
         sat_row = {2'b11, {(ROW_W-1){1'b0}}};
      end else begin
         sat_row = {2'b10, {(ROW_W-1){1'b1}}};
      end
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [4:0]       lvl_cfg_ff, lvl_cfg_in;
   logic [30:0]      intv_ff, intv_in;
   logic [LVL_W-1:0] run_lvl_ff, run_lvl_in;
   logic [30:0]      step_ff, step_in;
   logic [ROW_W-1:0] midsum_ff, midsum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [1:0]       phase_ff, phase_in;
   logic             clip_ff, clip_in;
   logic [LVL_W-1:0] j_ff, j_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [48:0]      op_ff, op_in;
   logic [47:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [62:0]      prod_ff, prod_in;
   logic [63:0]      acc_ff, acc_in;
   logic [T_W-1:0]   t_ff, t_in;
   logic [ROW_W-1:0] cur_ff, cur_in;
   logic [48:0]      d_ff, d_in;
   logic [S_W-1:0]   s_ff, s_in;
   logic [31:0]      est_ff, est_in;
   logic             sat_ff, sat_in;

   logic [ROW_W-1:0] row_ram_ff [MAX_LEVELS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [ROW_W-1:0] mem_wdata;

   logic [31:0]      mul_a;
   logic [62:0]      mul_p;
   logic [T_W-1:0]   mid_sum;
   logic [ROW_W:0]   mid_sat, half_sat, rich_sat;
   logic [CNT_W-1:0] cnt_next, blk_target;
   logic [48:0]      op_abs, d_abs;
   logic [63:0]      p_sum;
   logic [T_W-1:0]   t_base, t_rnd, t_half;
   logic [S_W-1:0]   a_ext, q_ext, s_adj;
   logic [Q_W:0]     q_full;
   logic [LVL_W-1:0] j_prev, level_prev, j_next;
   logic             out_free;
   logic             fits32;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   romb_div #(
      .Q_W (Q_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (q_full[Q_W-1:0]),
      .div_rsp (div_rsp)
   );

   assign mul_a = (state_ff == S_MULH) ? mag_ff[47:16] : {16'b0, mag_ff[15:0]};
   assign mul_p = mul_a * step_ff;

   assign mid_sum    = {{(T_W-ROW_W){midsum_ff[ROW_W-1]}}, midsum_ff}
                     + {{(T_W-32){req_sample_value[31]}}, req_sample_value};
   assign mid_sat    = sat_row(mid_sum);
   assign cnt_next   = cnt_ff + 1'b1;
   assign blk_target = CNT_W'(1) << (level_ff - LVL_W'(2));

   assign op_abs = op_ff[48] ? (~op_ff + 49'd1) : op_ff;
   assign p_sum  = acc_ff + {17'b0, prod_ff[62:16]};
   assign t_base = (phase_ff == PH_FB) ? '0 : {{(T_W-ROW_W){rd_data_ff[ROW_W-1]}}, rd_data_ff};

   // Halve toward zero
   assign t_rnd    = t_ff + T_W'(t_ff[T_W-1]);
   assign t_half   = {t_rnd[T_W-1], t_rnd[T_W-1:1]};
   assign half_sat = sat_row(t_half);

   assign d_abs  = d_ff[48] ? (~d_ff + 49'd1) : d_ff;
   assign q_full = ((Q_W+1)'(1) << {j_ff, 1'b0}) - (Q_W+1)'(1);
   assign a_ext  = {{(S_W-ROW_W){cur_ff[ROW_W-1]}}, cur_ff};
   assign q_ext  = {1'b0, div_rsp.quotient};
   // Floor quotient plus a, then step back toward zero when inexact and negative
   assign s_adj    = s_ff + S_W'(s_ff[S_W-1] & div_rsp.rem_nz);
   assign rich_sat = sat_row({{(T_W-S_W){s_adj[S_W-1]}}, s_adj});

   assign j_prev     = j_ff - 1'b1;
   assign j_next     = j_ff + 1'b1;
   assign level_prev = level_ff - 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fits32     = &cur_ff[47:31] || ~|cur_ff[47:31];

   assign div_req = '{start: (state_ff == S_DSTART), dividend: d_abs[DIV_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      lvl_cfg_in   = lvl_cfg_ff;
      intv_in      = intv_ff;
      run_lvl_in   = run_lvl_ff;
      step_in      = step_ff;
      midsum_in    = midsum_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      clip_in      = clip_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_in        = op_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      cur_in       = cur_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      est_in       = est_ff;
      sat_in       = sat_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = cur_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEVEL_COUNT:    lvl_cfg_in = csr_data[4:0];
            CSR_INTERVAL_WIDTH: intv_in    = csr_data[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (phase_ff)
                  PH_FA: begin
                     if (lvl_cfg_ff == 5'd0) begin
                        run_lvl_in = LVL_W'(1);
                     end else if (lvl_cfg_ff > 5'(MAX_LEVELS)) begin
                        run_lvl_in = LVL_W'(MAX_LEVELS);
                     end else begin
                        run_lvl_in = lvl_cfg_ff[LVL_W-1:0];
                     end
                     step_in   = intv_ff;
                     clip_in   = 1'b0;
                     midsum_in = {{(ROW_W-32){req_sample_value[31]}}, req_sample_value};
                     level_in  = LVL_W'(1);
                     cnt_in    = '0;
                     phase_in  = PH_FB;
                  end
                  PH_FB: begin
                     op_in    = {midsum_ff[ROW_W-1], midsum_ff}
                              + {{17{req_sample_value[31]}}, req_sample_value};
                     state_in = S_MAG;
                  end
                  default: begin
                     midsum_in = mid_sat[ROW_W-1:0];
                     if (mid_sat[ROW_W]) begin
                        clip_in = 1'b1;
                     end
                     cnt_in = cnt_next;
                     if (cnt_next == blk_target) begin
                        op_in    = {mid_sat[ROW_W-1], mid_sat[ROW_W-1:0]};
                        state_in = S_MAG;
                     end
                  end
               endcase
            end
         end
         S_MAG: begin
            mag_in    = op_abs[47:0];
            neg_in    = op_ff[48];
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = S_MULH;
         end
         S_MULH: begin
            prod_in  = mul_p;
            state_in = S_MULL;
         end
         S_MULL: begin
            acc_in   = {1'b0, prod_ff};
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            acc_in   = (p_sum > TERM_CAP) ? TERM_CAP : p_sum;
            state_in = S_TERM;
         end
         S_TERM: begin
            t_in     = neg_ff ? (t_base - acc_ff[T_W-1:0]) : (t_base + acc_ff[T_W-1:0]);
            state_in = S_HALF;
         end
         S_HALF: begin
            cur_in = half_sat[ROW_W-1:0];
            if (half_sat[ROW_W]) begin
               clip_in = 1'b1;
            end
            j_in     = LVL_W'(1);
            state_in = (level_ff > LVL_W'(1)) ? S_RD : S_FIN;
         end
         S_RD: begin
            mem_re    = 1'b1;
            mem_raddr = j_prev[IDX_W-1:0];
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            // Previous entry is consumed now: replace it with the new row value
            d_in      = {cur_ff[ROW_W-1], cur_ff} - {rd_data_ff[ROW_W-1], rd_data_ff};
            mem_we    = 1'b1;
            mem_waddr = j_prev[IDX_W-1:0];
            state_in  = S_DSTART;
         end
         S_DSTART: begin
            neg_in   = d_ff[48];
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_rsp.done) begin
               state_in = S_RSUM;
            end
         end
         S_RSUM: begin
            s_in     = neg_ff ? (a_ext + ~q_ext + S_W'(!div_rsp.rem_nz)) : (a_ext + q_ext);
            state_in = S_RSAT;
         end
         S_RSAT: begin
            cur_in = rich_sat[ROW_W-1:0];
            if (rich_sat[ROW_W]) begin
               clip_in = 1'b1;
            end
            j_in     = j_next;
            state_in = (j_next < level_ff) ? S_RD : S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = level_prev[IDX_W-1:0];
               if (phase_ff == PH_MID) begin
                  step_in = {1'b0, step_ff[30:1]};
               end
               if (level_ff >= run_lvl_ff) begin
                  if (fits32) begin
                     est_in = cur_ff[31:0];
                     sat_in = clip_ff;
                  end else begin
                     est_in  = cur_ff[ROW_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                     sat_in  = 1'b1;
                     clip_in = 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  phase_in     = PH_FA;
               end else begin
                  level_in  = level_ff + 1'b1;
                  midsum_in = '0;
                  cnt_in    = '0;
                  phase_in  = PH_MID;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_cfg_ff   <= 5'd1;
         intv_ff      <= 31'd65536;
         run_lvl_ff   <= LVL_W'(1);
         step_ff      <= '0;
         midsum_ff    <= '0;
         cnt_ff       <= '0;
         level_ff     <= LVL_W'(1);
         phase_ff     <= PH_FA;
         clip_ff      <= 1'b0;
         j_ff         <= LVL_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_cfg_ff   <= lvl_cfg_in;
         intv_ff      <= intv_in;
         run_lvl_ff   <= run_lvl_in;
         step_ff      <= step_in;
         midsum_ff    <= midsum_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         clip_ff      <= clip_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      cur_ff  <= cur_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      est_ff  <= est_in;
      sat_ff  <= sat_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_ram_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= row_ram_ff[mem_raddr];
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_estimate  = est_ff;
   assign rsp_saturated = sat_ff;
   assign csr_ready     = 1'b1;

endmodule
